// ----- rtl/core/chd_pkg.sv -----
// Shared types and constants for the canonical Huffman decoder.
package chd_pkg;

  localparam int WIN_W   = 16;
  localparam int LEN_W   = 5;
  localparam int SYM_W   = 9;
  localparam int CNT_W   = 10;
  localparam int LIM_W   = 18;
  localparam int OFS_W   = 32;
  localparam int MAXL    = 16;
  localparam int MAX_SYM = 512;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_BUILD  = 2'd1,
    ACT_DECODE = 2'd2,
    ACT_BAD    = 2'd3
  } action_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    action_t           act;
    logic [SYM_W-1:0]  sidx;
    logic [LEN_W-1:0]  clen;
    logic [CNT_W-1:0]  count;
    logic [WIN_W-1:0]  window;
    logic              err;
  } cmd_t;

  typedef struct packed {
    logic             status;
    logic [SYM_W-1:0] symbol;
    logic [LEN_W-1:0] bits_used;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HIST,
    ST_HIST_W,
    ST_LIMITS,
    ST_SORT,
    ST_SORT_W,
    ST_SINGLE,
    ST_SINGLE_W,
    ST_DEC_SCAN,
    ST_DEC_RD,
    ST_DEC_W,
    ST_OUT
  } st_t;

endpackage

// ----- rtl/core/chd_front.sv -----
// Input side: accepts items, checks ranges and classifies them.
module chd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [5:0]            in_tuser,
  input  logic [39:0]           in_tdata,
  output chd_pkg::cmd_t         cmd,
  output logic                  cmd_valid,
  input  logic                  cmd_ready
);
  import chd_pkg::*;

  cmd_t c;

  // Range checks; index is 9 bits so only length and count can be out of range
  always_comb begin
    c.act    = action_t'(in_tuser[1:0]);
    c.sidx   = in_tdata[8:0];
    c.clen   = in_tdata[13:9];
    c.count  = in_tdata[23:14];
    c.window = in_tdata[39:24];
    case (c.act)
      ACT_LOAD:   c.err = (c.clen > LEN_W'(MAXL));
      ACT_BUILD:  c.err = (c.count == '0) || (c.count > CNT_W'(MAX_SYM));
      ACT_DECODE: c.err = 1'b0;
      default:    c.err = 1'b1;
    endcase
  end

  // Two-entry queue toward the back end
  cmd_t q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
  end

endmodule

// ----- rtl/core/chd_back.sv -----
// Back end: length store, table build sequencer and decoder.
module chd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  chd_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  output chd_pkg::res_t  res,
  output logic           res_valid,
  input  logic           res_ready
);
  import chd_pkg::*;

  // Memories
  logic [LEN_W-1:0] len_mem [MAX_SYM];
  logic [SYM_W-1:0] sort_mem [MAX_SYM];
  logic [LEN_W-1:0] len_q_r;
  logic [SYM_W-1:0] sort_q_r;

  // Per-length tables (index 0 unused)
  logic [LIM_W-1:0] lim_r  [MAXL+1];
  logic [OFS_W-1:0] base_r [MAXL+1];
  logic [CNT_W-1:0] hist_r [MAXL+1];
  logic [CNT_W-1:0] pos_r  [MAXL+1];
  logic [CNT_W-1:0] used_r, count_r, single_r;
  logic [OFS_W-1:0] next_r;
  logic [LEN_W-1:0] l_r;
  logic [CNT_W-1:0] s_r;
  logic [WIN_W-1:0] win_r;
  logic [OFS_W-1:0] idx_r;

  st_t  st_r, st_nxt;
  res_t res_r;
  logic rv_r;

  logic [CNT_W-1:0] hn;
  logic [47:0]      lim_full;
  logic [16:0]      kwin;
  logic [3:0]       sh;

  assign res       = res_r;
  assign res_valid = rv_r;
  assign cmd_ready = (st_r == ST_IDLE) && !rv_r;

  assign hn   = hist_r[l_r];
  assign sh   = 4'(5'(WIN_W) - l_r);
  assign lim_full = ((48'(next_r + 32'(hn) - 32'd1)) << sh) | ((48'd1 << sh) - 48'd1);
  assign kwin = {1'b0, win_r} + 17'd1;

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:
        if (cmd_valid && !rv_r) begin
          if (cmd.err || cmd.act == ACT_LOAD) st_nxt = ST_OUT;
          else if (cmd.act == ACT_BUILD) st_nxt = ST_HIST;
          else if (single_r != '0) st_nxt = ST_OUT;
          else st_nxt = ST_DEC_SCAN;
        end
      ST_HIST:     st_nxt = ST_HIST_W;
      ST_HIST_W:   st_nxt = (s_r == count_r) ? ST_LIMITS : ST_HIST;
      ST_LIMITS:   if (l_r == LEN_W'(MAXL)) st_nxt = ST_SORT;
      ST_SORT:     st_nxt = (used_r <= 10'd1) ? ST_SINGLE : ST_SORT_W;
      ST_SORT_W:   st_nxt = (s_r == count_r) ? ST_OUT : ST_SORT_W;
      ST_SINGLE:   st_nxt = ST_SINGLE_W;
      ST_SINGLE_W: st_nxt = (s_r == count_r || len_q_r != '0) ? ST_OUT : ST_SINGLE_W;
      ST_DEC_SCAN:
        if ((lim_r[l_r] != '0 && 18'(kwin) <= lim_r[l_r]) || l_r == LEN_W'(MAXL))
          st_nxt = ST_DEC_RD;
      ST_DEC_RD:   st_nxt = ST_DEC_W;
      ST_DEC_W:    st_nxt = ST_OUT;
      ST_OUT:      st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // Memory ports: one read address chosen per state
  logic [8:0] rd_addr;
  always_comb begin
    rd_addr = s_r[8:0];
    if (st_r == ST_DEC_RD) rd_addr = idx_r[8:0];
  end
  always_ff @(posedge clk) begin
    len_q_r  <= len_mem[rd_addr];
    sort_q_r <= sort_mem[rd_addr];
    if (st_r == ST_IDLE && cmd_valid && !rv_r && cmd.act == ACT_LOAD && !cmd.err)
      len_mem[cmd.sidx] <= cmd.clen;
    if (st_r == ST_SORT_W && s_r != '0 && len_q_r != '0)
      sort_mem[pos_r[len_q_r][8:0]] <= SYM_W'(s_r - 10'd1);
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r     <= 1'b0;
      single_r <= '0;
      used_r   <= '0;
      for (int i = 0; i <= MAXL; i++) begin
        lim_r[i]  <= '0;
        base_r[i] <= '0;
      end
    end else begin
      if (rv_r && res_ready) rv_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (cmd_valid && !rv_r) begin
          // single-symbol decode answers straight away
          res_r   <= '{status: cmd.err,
                       symbol: (!cmd.err && cmd.act == ACT_DECODE && single_r != '0) ?
                               SYM_W'(single_r - 10'd1) : '0,
                       bits_used: '0};
          s_r     <= '0;
          l_r     <= 5'd1;
          win_r   <= cmd.window;
          count_r <= cmd.count;
          next_r  <= '0;
          for (int i = 0; i <= MAXL; i++) hist_r[i] <= '0;
          if (!cmd.err && cmd.act == ACT_BUILD) used_r <= '0;
        end
        ST_HIST: s_r <= s_r + 10'd1;
        ST_HIST_W: hist_r[len_q_r] <= hist_r[len_q_r] + 10'd1;
        ST_LIMITS: begin
          if (hn == '0) begin
            lim_r[l_r]  <= '0;
            base_r[l_r] <= '0;
          end else begin
            lim_r[l_r]  <= (lim_full + 48'd1 > 48'h3FFFF) ? 18'h3FFFF
                                                          : 18'(lim_full + 48'd1);
            base_r[l_r] <= 32'(used_r) - next_r;
            pos_r[l_r]  <= used_r;
          end
          used_r <= used_r + hn;
          next_r <= (next_r + 32'(hn)) << 1;
          l_r    <= l_r + 5'd1;
        end
        ST_SORT: begin
          s_r <= 10'd0;
          single_r <= '0;
        end
        ST_SORT_W: begin
          // read of s_r issued this cycle, data for s_r-1 arrives now
          if (s_r != '0 && len_q_r != '0)
            pos_r[len_q_r] <= pos_r[len_q_r] + 10'd1;
          if (s_r != count_r) s_r <= s_r + 10'd1;
        end
        ST_SINGLE: begin
          s_r <= 10'd1;
          single_r <= 10'd1;
        end
        ST_SINGLE_W: begin
          if (len_q_r != '0) single_r <= s_r;
          else if (s_r != count_r) s_r <= s_r + 10'd1;
        end
        ST_DEC_SCAN:
          if ((lim_r[l_r] != '0 && 18'(kwin) <= lim_r[l_r]) || l_r == LEN_W'(MAXL)) begin
            if (!(lim_r[l_r] != '0 && 18'(kwin) <= lim_r[l_r])) res_r.status <= 1'b1;
            idx_r <= base_r[l_r] + 32'(win_r >> sh);
          end else l_r <= l_r + 5'd1;
        ST_DEC_RD:
          if (idx_r >= 32'(used_r) || idx_r >= 32'(MAX_SYM)) res_r.status <= 1'b1;
        ST_DEC_W:
          if (!res_r.status) begin
            res_r.symbol    <= sort_q_r;
            res_r.bits_used <= l_r;
          end
        ST_OUT: rv_r <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/canonical_huffman_decoder_top.sv -----
// Top level of the canonical Huffman decoder.
//  channel | dir | fields
//  in_     | in  | tuser: action; tdata: symbol_index, code_length, symbol_count, code_window
//  out_    | out | tdata: status, symbol, bits_used
// A load, an error or a single-symbol decode is answered without a table scan; other
// decodes are paced by the serial scan over the 16 length limits, and a build by the
// single read port of the length store.
// Reset is synchronous, active low.
// A two-entry queue accepts items while the back end works or the output stalls.
module canonical_huffman_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [5:0]  in_tuser,   // [1:0] action
  input  logic [39:0] in_tdata,   // symbol_index, code_length, symbol_count, code_window
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status, symbol, bits_used
);
  import chd_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_ready;

  chd_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .cmd, .cmd_valid, .cmd_ready
  );

  chd_back u_back (
    .clk, .rst_n, .cmd, .cmd_valid, .cmd_ready,
    .res, .res_valid(out_tvalid), .res_ready(out_tready)
  );

  assign out_tdata = {1'b0, res.bits_used, res.symbol, res.status};

endmodule

// ----- sim/tb_canonical_huffman_decoder_top.sv -----
// Self-checking testbench for the canonical Huffman decoder top level.
`timescale 1ns / 1ps

module tb_canonical_huffman_decoder_top;
  import chd_pkg::*;

  typedef struct {
    action_t    act;
    bit [8:0]   sidx;
    bit [4:0]   clen;
    bit [9:0]   cnt;
    bit [15:0]  win;
    bit         typed;   // expected result given in the row
    bit         st;
    bit [8:0]   sym;
    bit [4:0]   nbits;
  } item_t;

  typedef struct {
    bit        st;
    bit [8:0]  sym;
    bit [4:0]  nbits;
  } dec_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [5:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  canonical_huffman_decoder_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder image kept by the testbench
  bit [4:0]  code_len [512];
  bit [8:0]  by_length [512];
  bit [31:0] len_limit [17];
  bit [31:0] len_base [17];
  bit [31:0] n_used;
  bit [31:0] lone_sym;

  item_t     stim_q[$];
  dec_res_t  result_q[$];
  int        n_sent, n_total, idle_mode;
  int        n_checked, n_errors, n_decodes, n_builds;
  int        n_acc;
  bit        pressure_done;

  // Directed items; rows with typed set carry their own expected result
  item_t dir_tab[25] = '{
    '{ACT_DECODE, 0,   0,  0,    16'h0000, 1, 1, 0, 0},  // decode before any build
    '{ACT_BUILD,  0,   0,  0,    16'h0000, 1, 1, 0, 0},  // zero count
    '{ACT_BUILD,  0,   0,  1023, 16'h0000, 1, 1, 0, 0},  // count too large
    '{ACT_BUILD,  0,   0,  513,  16'h0000, 1, 1, 0, 0},
    '{ACT_LOAD,   0,   31, 0,    16'h0000, 1, 1, 0, 0},  // length too large
    '{ACT_LOAD,   511, 17, 0,    16'h0000, 1, 1, 0, 0},
    '{ACT_BAD,    511, 31, 1023, 16'hFFFF, 1, 1, 0, 0},  // unknown action
    '{ACT_LOAD,   0,   1,  0,    16'h0000, 1, 0, 0, 0},
    '{ACT_LOAD,   1,   2,  0,    16'h0000, 1, 0, 0, 0},
    '{ACT_LOAD,   2,   3,  0,    16'h0000, 1, 0, 0, 0},
    '{ACT_LOAD,   3,   3,  0,    16'h0000, 1, 0, 0, 0},
    '{ACT_BUILD,  0,   0,  4,    16'h0000, 1, 0, 0, 0},
    '{ACT_DECODE, 0,   0,  0,    16'h0000, 1, 0, 0, 1},
    '{ACT_DECODE, 0,   0,  0,    16'hFFFF, 1, 0, 3, 3},
    '{ACT_DECODE, 0,   0,  0,    16'h8000, 0, 0, 0, 0},
    '{ACT_DECODE, 0,   0,  0,    16'hC000, 0, 0, 0, 0},
    '{ACT_LOAD,   1,   0,  0,    16'h0000, 0, 0, 0, 0},
    '{ACT_LOAD,   2,   0,  0,    16'h0000, 0, 0, 0, 0},
    '{ACT_LOAD,   3,   0,  0,    16'h0000, 0, 0, 0, 0},
    '{ACT_BUILD,  0,   0,  4,    16'h0000, 0, 0, 0, 0},
    '{ACT_DECODE, 0,   0,  0,    16'hABCD, 1, 0, 0, 0},  // one symbol left: no bits used
    '{ACT_LOAD,   0,   16, 0,    16'h0000, 0, 0, 0, 0},
    '{ACT_LOAD,   1,   16, 0,    16'h0000, 0, 0, 0, 0},
    '{ACT_BUILD,  0,   0,  2,    16'h0000, 0, 0, 0, 0},
    '{ACT_DECODE, 0,   0,  0,    16'hFFFF, 0, 0, 0, 0}   // beyond the last code
  };

  // Table build from the stored lengths
  function automatic dec_res_t build_tables(bit [9:0] cnt);
    bit [31:0]       hist [17];
    bit [31:0]       slot [17];
    bit [31:0]       nxt, used, p;
    longint unsigned lim;
    int              sh;
    dec_res_t        r;
    r = '{0, 0, 0};
    if (cnt == 0 || cnt > 512) begin
      r.st = 1;
      return r;
    end
    nxt = 0;
    used = 0;
    for (int l = 0; l <= 16; l++) begin
      hist[l] = 0;
      slot[l] = 0;
    end
    for (int s = 0; s < cnt; s++) hist[code_len[s]]++;
    for (int l = 1; l <= 16; l++) begin
      if (hist[l] == 0) begin
        len_limit[l] = 0;
        len_base[l] = 0;
      end else begin
        sh = 16 - l;
        lim = ((longint'(nxt + hist[l] - 1) << sh) | ((64'd1 << sh) - 1)) + 1;
        len_limit[l] = (lim > 64'h3FFFF) ? 32'h3FFFF : lim[31:0];
        len_base[l] = used - nxt;
        slot[l] = used;
        used += hist[l];
        nxt += hist[l];
      end
      nxt = nxt << 1;
    end
    n_used = used;
    if (used <= 1) begin
      lone_sym = 1;
      for (int s = 0; s < cnt; s++)
        if (code_len[s] != 0) begin
          lone_sym = s + 1;
          break;
        end
      return r;
    end
    lone_sym = 0;
    for (int s = 0; s < cnt; s++)
      if (code_len[s] != 0) begin
        p = slot[code_len[s]]++;
        if (p < 512) by_length[p] = s[8:0];
      end
    return r;
  endfunction

  function automatic dec_res_t decode_window(bit [15:0] win);
    bit [31:0] k, idx;
    int        l;
    dec_res_t  r;
    r = '{1, 0, 0};
    if (lone_sym != 0) return '{0, lone_sym[8:0] - 9'd1, 0};
    k = win + 1;
    for (l = 1; l <= 16; l++)
      if (len_limit[l] != 0 && k <= len_limit[l]) break;
    if (l > 16) return r;
    idx = len_base[l] + (win >> (16 - l));
    if (idx >= n_used || idx >= 512) return r;
    return '{0, by_length[idx], l[4:0]};
  endfunction

  function automatic dec_res_t predict(item_t it);
    dec_res_t r;
    r = '{1, 0, 0};
    case (it.act)
      ACT_LOAD: if (it.clen <= 16) begin
        code_len[it.sidx] = it.clen;
        r.st = 0;
      end
      ACT_BUILD: begin
        r = build_tables(it.cnt);
        n_builds++;
      end
      ACT_DECODE: begin
        r = decode_window(it.win);
        n_decodes++;
      end
      default: r.st = 1;
    endcase
    return r;
  endfunction

  function automatic item_t mk(action_t act, int sidx, int clen, int cnt, int win);
    item_t it;
    it = '{act, sidx[8:0], clen[4:0], cnt[9:0], win[15:0], 0, 0, 0, 0};
    return it;
  endfunction

  // Random stimulus: code sets loaded, built and decoded, with noise between
  task automatic gen_random();
    bit [4:0] lens [512];
    int       n, j, tries, cnt;
    bit       first;
    first = 1;
    while (stim_q.size() < 1650) begin
      n = first ? 512 : (($urandom_range(9) == 0) ? $urandom_range(1, 3) :
                                                     $urandom_range(2, 40));
      // complete code by leaf splitting, or arbitrary lengths
      if ($urandom_range(1) == 0 && n >= 2) begin
        lens[0] = 1;
        lens[1] = 1;
        for (int i = 2; i < n; i++) begin
          tries = 0;
          do begin
            j = $urandom_range(i - 1);
            tries++;
          end while (lens[j] >= 16 && tries < 20);
          if (lens[j] < 16) begin
            lens[j]++;
            lens[i] = lens[j];
          end else lens[i] = 0;
        end
      end else begin
        j = $urandom_range(1, 16);
        for (int i = 0; i < n; i++)
          lens[i] = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, j);
      end
      for (int i = 0; i < n; i++) begin
        stim_q.push_back(mk(ACT_LOAD, i, lens[i], $urandom, $urandom));
        if ($urandom_range(24) == 0)
          case ($urandom_range(2))
            0: stim_q.push_back(mk(ACT_LOAD, $urandom, $urandom_range(17, 31), $urandom,
                                   $urandom));
            1: stim_q.push_back(mk(ACT_BAD, $urandom, $urandom, $urandom, $urandom));
            default: stim_q.push_back(mk(ACT_BUILD, $urandom, $urandom,
                                         ($urandom_range(1) ? 0 : $urandom_range(513, 1023)),
                                         $urandom));
          endcase
      end
      // all entries are written once the first set is in
      cnt = (!first && $urandom_range(7) == 0) ? $urandom_range(1, 512) : n;
      stim_q.push_back(mk(ACT_BUILD, $urandom, $urandom, cnt, $urandom));
      first = 0;
      for (int i = $urandom_range(5, 24); i > 0; i--) begin
        j = $urandom;
        if ($urandom_range(1)) j = j | ~(16'hFFFF >> $urandom_range(1, 16));
        stim_q.push_back(mk(ACT_DECODE, $urandom, $urandom, $urandom, j));
      end
    end
  endtask

  // Sender
  initial begin
    item_t it;
    int    gap_pct;
    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    gen_random();
    n_total = stim_q.size();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (stim_q[i]) begin
      it = stim_q[i];
      idle_mode = (i * 4) / n_total;
      gap_pct = (idle_mode == 1) ? 59 : (idle_mode == 3) ? 14 : 0;
      while ($urandom_range(99) < gap_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser <= {4'd0, it.act};
      in_tdata <= {it.win, it.cnt, it.clen, it.sidx};
      do @(posedge clk); while (!in_tready);
      n_sent++;
    end
    in_tvalid <= 1'b0;
    for (int w = 0; w < 200000 && result_q.size() != 0; w++) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, result_q.size());
      n_errors++;
    end
    $display("Ran %0d items (%0d builds, %0d decodes); %0d results checked.",
             n_total, n_builds, n_decodes, n_checked);
    $display("Covered bad loads/counts, single-symbol, incomplete and oversubscribed codes.");
    if (n_errors == 0) begin
      $display("canonical_huffman_decoder_top: match");
    end else begin
      $display("canonical_huffman_decoder_top: mismatch");
    end
    $finish;
  end

  // Receiver, with one long hold-off to back up the input
  initial begin
    int stall_pct, hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!pressure_done && n_sent >= 700) begin
        pressure_done = 1;
        hold = 300;
      end
      stall_pct = (idle_mode == 2) ? 59 : (idle_mode == 3) ? 14 : 0;
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Accepted input items feed the predictor
  always @(posedge clk) begin
    item_t    it;
    dec_res_t r;
    if (rst_n && in_tvalid && in_tready) begin
      it = mk(action_t'(in_tuser[1:0]), in_tdata[8:0], in_tdata[13:9], in_tdata[23:14],
              in_tdata[39:24]);
      r = predict(it);
      // directed rows with a typed result use it
      if (n_acc < 25 && dir_tab[n_acc].typed)
        r = '{dir_tab[n_acc].st, dir_tab[n_acc].sym, dir_tab[n_acc].nbits};
      n_acc++;
      result_q.push_back(r);
    end
  end

  // Result check
  always @(posedge clk) begin
    dec_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_tdata);
        n_errors++;
      end else begin
        e = result_q.pop_front();
        n_checked++;
        if (out_tdata[0] !== e.st || out_tdata[9:1] !== e.sym ||
            out_tdata[14:10] !== e.nbits || out_tdata[15] !== 1'b0) begin
          $display("%0t: expected status %0d symbol %0d bits %0d, got status %0d symbol %0d bits %0d",
                   $realtime, e.st, e.sym, e.nbits, out_tdata[0], out_tdata[9:1],
                   out_tdata[14:10]);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #30ms;
    $display("canonical_huffman_decoder_top: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/chd_pkg.sv
rtl/core/chd_front.sv
rtl/core/chd_back.sv
rtl/core/canonical_huffman_decoder_top.sv
sim/tb_canonical_huffman_decoder_top.sv
